@@ src/brc_pkg.sv @@
// Shared types, constants and helpers for the bit-sliced block rank counter.
// Depends on nothing; every module refers to it by scoped names.
package brc_pkg;

	localparam int WORDS_PER_BLOCK = 4;
	localparam int WORD_IDX_W      = (WORDS_PER_BLOCK > 1) ? $clog2(WORDS_PER_BLOCK) : 1;
	localparam int WORD_BITS       = 64;
	localparam int WORD_LSB_W      = 6;
	localparam int NUM_PLANES      = 5;
	localparam int NUC_PLANES      = 2;
	localparam int CODE_W          = 5;
	localparam int QPOS_W          = 8;
	localparam int QHI_W           = QPOS_W - WORD_LSB_W;
	localparam int CMP_W           = (WORD_IDX_W > QHI_W) ? WORD_IDX_W : QHI_W;
	localparam int COUNT_W         = 9;
	localparam int POP_W           = 7;

	localparam int IN_BITS      = NUM_PLANES * WORD_BITS + CODE_W + QPOS_W;
	localparam int S_TDATA_W    = ((IN_BITS + 7) / 8) * 8;
	localparam int CODE_LSB     = NUM_PLANES * WORD_BITS;
	localparam int QPOS_LSB     = CODE_LSB + CODE_W;
	localparam int M_TDATA_W    = ((COUNT_W + 7) / 8) * 8;

	localparam int FIFO_DEPTH   = 2;
	localparam int FIFO_PTR_W   = 1;
	localparam int FIFO_CNT_W   = 2;

	localparam logic [WORD_IDX_W-1:0] LAST_WORD = WORD_IDX_W'(WORDS_PER_BLOCK - 1);

	// alphabet_mode encodings
	localparam logic MODE_NUC   = 1'b0;
	localparam logic MODE_AMINO = 1'b1;

	// One classified word: position-masked match vector, end-of-block mark.
	typedef struct packed {
		logic [WORD_BITS-1:0] match;
		logic                 last;
	} brc_entry_t;

	function automatic logic [POP_W-1:0] popcount64(input logic [WORD_BITS-1:0] v);
		logic [POP_W-1:0] n;
		n = '0;
		for (int i = 0; i < WORD_BITS; i++) begin
			n = n + POP_W'(v[i]);
		end
		return n;
	endfunction

endpackage

@@ src/bitsliced_block_rank_count_top.sv @@
// Top level of the bit-sliced block rank counter: front end, word queue, back end.
// Depends on brc_pkg, brc_front, brc_fifo and brc_back.
//
// Channel   Dir  Beat contents (low bit first)
// s_*       in   plane0..plane4 words, symbol_code, query_pos (one block word)
// m_*       out  occurrence_count (one per block, after the last word)
// cfg_*     in   alphabet_mode (0 nucleotide / 1 amino acid)
//
// Throughput: one input beat per cycle while s_tready is high. The front end
// classifies a word in the accept cycle and writes it to a two-entry queue; the
// back end popcounts and accumulates one queued word per cycle unless a last word
// waits for the output slot, and registers each block total for m_*. s_tready drops
// only when the queue is full, only while m_tready low holds a finished total.
// Reset clears the mode, word counter, accumulator, queue and output valid.
module bitsliced_block_rank_count_top (
	input  logic                           clk,
	input  logic                           arst_n,
	// alphabet mode register write
	input  logic                           cfg_wr_en,
	input  logic                           cfg_wr_data,
	// input stream
	input  logic                           s_tvalid,
	output logic                           s_tready,
	// [63:0] plane0_word, [127:64] plane1_word, [191:128] plane2_word,
	// [255:192] plane3_word, [319:256] plane4_word, [324:320] symbol_code,
	// [332:325] query_pos, [335:333] zero
	input  logic [brc_pkg::S_TDATA_W-1:0]  s_tdata,
	// output stream
	output logic                           m_tvalid,
	input  logic                           m_tready,
	// [8:0] occurrence_count, [15:9] zero
	output logic [brc_pkg::M_TDATA_W-1:0]  m_tdata
);

	logic                 q_push;
	logic                 q_full;
	logic                 q_pop;
	logic                 q_not_empty;
	brc_pkg::brc_entry_t  q_in;
	brc_pkg::brc_entry_t  q_head;

	// Front end: mode register, word counter, compare and position mask.
	brc_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.s_tvalid    (s_tvalid),
		.s_tready    (s_tready),
		.s_tdata     (s_tdata),
		.q_full      (q_full),
		.q_push      (q_push),
		.q_entry     (q_in)
	);

	// Decouples the two sides so the front keeps taking words during a stall, until the queue fills.
	brc_fifo u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (q_push),
		.push_entry (q_in),
		.full       (q_full),
		.pop        (q_pop),
		.not_empty  (q_not_empty),
		.head       (q_head)
	);

	// Back end: popcount, per-block accumulation, output register.
	brc_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.q_not_empty (q_not_empty),
		.q_head      (q_head),
		.q_pop       (q_pop),
		.m_tvalid    (m_tvalid),
		.m_tready    (m_tready),
		.m_tdata     (m_tdata)
	);

endmodule

@@ src/brc_front.sv @@
// Front end: accepts input beats, holds the alphabet mode and word counter,
// and turns each word into a position-masked match vector. Uses brc_pkg.
module brc_front (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_wr_en,
	input  logic                           cfg_wr_data,
	input  logic                           s_tvalid,
	output logic                           s_tready,
	input  logic [brc_pkg::S_TDATA_W-1:0]  s_tdata,
	input  logic                           q_full,
	output logic                           q_push,
	output brc_pkg::brc_entry_t            q_entry
);

	logic                              mode_q;
	logic [brc_pkg::WORD_IDX_W-1:0]    wcnt_q;
	logic [brc_pkg::CODE_W-1:0]        code;
	logic [brc_pkg::QPOS_W-1:0]        qpos;
	logic [brc_pkg::WORD_BITS-1:0]     plane_word [brc_pkg::NUM_PLANES];
	logic [brc_pkg::WORD_BITS-1:0]     match;
	logic [brc_pkg::WORD_BITS-1:0]     pos_mask;
	logic [brc_pkg::CMP_W-1:0]         qhi;
	logic [brc_pkg::CMP_W-1:0]         widx;
	logic                              is_last;

	assign s_tready = !q_full;
	assign q_push   = s_tvalid && !q_full;

	assign code = s_tdata[brc_pkg::CODE_LSB +: brc_pkg::CODE_W];
	assign qpos = s_tdata[brc_pkg::QPOS_LSB +: brc_pkg::QPOS_W];

	always_comb begin
		for (int p = 0; p < brc_pkg::NUM_PLANES; p++) begin
			plane_word[p] = s_tdata[p*brc_pkg::WORD_BITS +: brc_pkg::WORD_BITS];
		end
	end

	// All active planes must agree with the code bit at a position.
	always_comb begin
		match = '1;
		for (int p = 0; p < brc_pkg::NUM_PLANES; p++) begin
			if (p < brc_pkg::NUC_PLANES || mode_q == brc_pkg::MODE_AMINO) begin
				match = match & (code[p] ? plane_word[p] : ~plane_word[p]);
			end
		end
	end

	// Word fully below query: all ones; word holding query: thermometer; above: none.
	assign qhi  = brc_pkg::CMP_W'(qpos[brc_pkg::QPOS_W-1:brc_pkg::WORD_LSB_W]);
	assign widx = brc_pkg::CMP_W'(wcnt_q);

	always_comb begin
		for (int i = 0; i < brc_pkg::WORD_BITS; i++) begin
			if (qhi > widx) begin
				pos_mask[i] = 1'b1;
			end else if (qhi == widx) begin
				pos_mask[i] = (brc_pkg::WORD_LSB_W'(i) <= qpos[brc_pkg::WORD_LSB_W-1:0]);
			end else begin
				pos_mask[i] = 1'b0;
			end
		end
	end

	assign is_last       = (wcnt_q == brc_pkg::LAST_WORD);
	assign q_entry.match = match & pos_mask;
	assign q_entry.last  = is_last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= brc_pkg::MODE_NUC;
			wcnt_q <= '0;
		end else begin
			if (cfg_wr_en) begin
				mode_q <= cfg_wr_data;
			end
			if (q_push) begin
				wcnt_q <= is_last ? '0 : wcnt_q + 1'b1;
			end
		end
	end

endmodule

@@ src/brc_fifo.sv @@
// Two-entry queue of classified words between front and back end.
// Uses brc_pkg for the entry type and depth constants.
module brc_fifo (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	input  brc_pkg::brc_entry_t  push_entry,
	output logic                 full,
	input  logic                 pop,
	output logic                 not_empty,
	output brc_pkg::brc_entry_t  head
);

	brc_pkg::brc_entry_t              mem_q [brc_pkg::FIFO_DEPTH];
	logic [brc_pkg::FIFO_PTR_W-1:0]   wr_ptr_q;
	logic [brc_pkg::FIFO_PTR_W-1:0]   rd_ptr_q;
	logic [brc_pkg::FIFO_CNT_W-1:0]   cnt_q;

	assign full      = (cnt_q == brc_pkg::FIFO_CNT_W'(brc_pkg::FIFO_DEPTH));
	assign not_empty = (cnt_q != '0);
	assign head      = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			unique case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

@@ src/brc_back.sv @@
// Back end: popcounts queued match vectors, accumulates per block and holds
// the block total in the output register. Uses brc_pkg.
module brc_back (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           q_not_empty,
	input  brc_pkg::brc_entry_t            q_head,
	output logic                           q_pop,
	output logic                           m_tvalid,
	input  logic                           m_tready,
	output logic [brc_pkg::M_TDATA_W-1:0]  m_tdata
);

	logic [brc_pkg::COUNT_W-1:0] acc_q;
	logic [brc_pkg::COUNT_W-1:0] out_count_q;
	logic                        out_valid_q;
	logic [brc_pkg::COUNT_W-1:0] total;
	logic                        out_free;

	// A finished total can only move in when the output slot is empty or drains this cycle.
	assign out_free = !out_valid_q || m_tready;
	assign q_pop    = q_not_empty && (!q_head.last || out_free);
	assign total    = acc_q + brc_pkg::COUNT_W'(brc_pkg::popcount64(q_head.match));

	assign m_tvalid = out_valid_q;
	assign m_tdata  = brc_pkg::M_TDATA_W'(out_count_q);

	always_ff @(posedge clk) begin
		if (q_pop && q_head.last) begin
			out_count_q <= total;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (q_pop) begin
				acc_q <= q_head.last ? '0 : total;
			end
			if (q_pop && q_head.last) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule
